### src/sso_pkg.sv
// Shared types, constants and tables for the skid-steer odometry core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sso_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int POSITION_WIDTH = 48;
    localparam int ANGLE_WIDTH    = 16;
    localparam int MPC_WIDTH      = 32;
    localparam int LIMIT_WIDTH    = 31;
    localparam int TIME_WIDTH     = 24;
    localparam int VEL_WIDTH      = 32;
    localparam int CORDIC_WIDTH   = 34;
    localparam int CORDIC_STEPS   = 30;
    localparam int DIV_STEPS      = 32;
    localparam int ITER_WIDTH     = 5;
    localparam int IN_WIDTH       = 4 * COUNT_WIDTH + ANGLE_WIDTH + TIME_WIDTH;
    localparam int OUT_WIDTH      = 2 * POSITION_WIDTH + ANGLE_WIDTH + 2 * VEL_WIDTH;
    localparam int USER_WIDTH     = 2;

    localparam logic [MPC_WIDTH-1:0]   MPC_RESET   = 32'd272374;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 31'd15000;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] US_PER_S = 32'd1000000;

    localparam logic REG_MPC   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_GLITCH, OP_SUMS, OP_SUM, OP_MAG, OP_MD_LO, OP_MD_HI,
        OP_DIST, OP_CINIT, OP_CSTEP, OP_CROT, OP_XLO, OP_XHI, OP_YLO, OP_YHI,
        OP_POSY, OP_NLO, OP_NHI, OP_DINIT, OP_DPRE, OP_DSTEP, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GLITCH, ST_SUMS, ST_SUM, ST_MAG, ST_MD_LO, ST_MD_HI, ST_DIST,
        ST_CINIT, ST_CSTEP, ST_CROT, ST_XLO, ST_XHI, ST_YLO, ST_YHI, ST_POSY,
        ST_NLO, ST_NHI, ST_DINIT, ST_DPRE, ST_DSTEP, ST_DONE
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [ITER_WIDTH-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

    // atan(2^-i), 2^32 units per turn
    function automatic logic signed [CORDIC_WIDTH-1:0] atan_step(input logic [ITER_WIDTH-1:0] i);
        logic signed [CORDIC_WIDTH-1:0] a;
        case (i)
            5'd0:    a = 34'sh20000000;
            5'd1:    a = 34'sh12E4051E;
            5'd2:    a = 34'sh09FB385B;
            5'd3:    a = 34'sh051111D4;
            5'd4:    a = 34'sh028B0D43;
            5'd5:    a = 34'sh0145D7E1;
            5'd6:    a = 34'sh00A2F61E;
            5'd7:    a = 34'sh00517C55;
            5'd8:    a = 34'sh0028BE53;
            5'd9:    a = 34'sh00145F2F;
            5'd10:   a = 34'sh000A2F98;
            5'd11:   a = 34'sh000517CC;
            5'd12:   a = 34'sh00028BE6;
            5'd13:   a = 34'sh000145F3;
            5'd14:   a = 34'sh0000A2FA;
            5'd15:   a = 34'sh0000517D;
            5'd16:   a = 34'sh000028BE;
            5'd17:   a = 34'sh0000145F;
            5'd18:   a = 34'sh00000A30;
            5'd19:   a = 34'sh00000518;
            5'd20:   a = 34'sh0000028C;
            5'd21:   a = 34'sh00000146;
            5'd22:   a = 34'sh000000A3;
            5'd23:   a = 34'sh00000051;
            5'd24:   a = 34'sh00000029;
            5'd25:   a = 34'sh00000014;
            5'd26:   a = 34'sh0000000A;
            5'd27:   a = 34'sh00000005;
            5'd28:   a = 34'sh00000003;
            5'd29:   a = 34'sh00000001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### src/sso_ctrl.sv
// Sequencer for the odometry core: walks one transaction through the datapath.
// Depends on sso_pkg.
`timescale 1ns / 1ps

module sso_ctrl import sso_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t                state_reg, state_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next;
    logic                  accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = '0;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_GLITCH;
            ST_GLITCH: state_next = ST_SUMS;
            ST_SUMS:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_MAG;
            ST_MAG:    state_next = ST_MD_LO;
            ST_MD_LO:  state_next = ST_MD_HI;
            ST_MD_HI:  state_next = ST_DIST;
            ST_DIST:   state_next = ST_CINIT;
            ST_CINIT:  state_next = ST_CSTEP;
            ST_CSTEP:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_WIDTH'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_CROT;
                    iter_next  = '0;
                end
            end
            ST_CROT:   state_next = ST_XLO;
            ST_XLO:    state_next = ST_XHI;
            ST_XHI:    state_next = ST_YLO;
            ST_YLO:    state_next = ST_YHI;
            ST_YHI:    state_next = ST_POSY;
            ST_POSY:   state_next = ST_NLO;
            ST_NLO:    state_next = ST_NHI;
            ST_NHI:    state_next = ST_DINIT;
            ST_DINIT:  state_next = ST_DPRE;
            ST_DPRE:   state_next = ST_DSTEP;
            ST_DSTEP:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_WIDTH'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                    iter_next  = '0;
                end
            end
            ST_DONE:   if (!stat.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.iter = iter_reg;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            ST_GLITCH: cmd.op = OP_GLITCH;
            ST_SUMS:   cmd.op = OP_SUMS;
            ST_SUM:    cmd.op = OP_SUM;
            ST_MAG:    cmd.op = OP_MAG;
            ST_MD_LO:  cmd.op = OP_MD_LO;
            ST_MD_HI:  cmd.op = OP_MD_HI;
            ST_DIST:   cmd.op = OP_DIST;
            ST_CINIT:  cmd.op = OP_CINIT;
            ST_CSTEP:  cmd.op = OP_CSTEP;
            ST_CROT:   cmd.op = OP_CROT;
            ST_XLO:    cmd.op = OP_XLO;
            ST_XHI:    cmd.op = OP_XHI;
            ST_YLO:    cmd.op = OP_YLO;
            ST_YHI:    cmd.op = OP_YHI;
            ST_POSY:   cmd.op = OP_POSY;
            ST_NLO:    cmd.op = OP_NLO;
            ST_NHI:    cmd.op = OP_NHI;
            ST_DINIT:  cmd.op = OP_DINIT;
            ST_DPRE:   cmd.op = OP_DPRE;
            ST_DSTEP:  cmd.op = OP_DSTEP;
            ST_DONE:   if (!stat.out_busy) cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_GLITCH)
        else $error("accepted transaction did not start processing");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CSTEP |-> iter_reg < ITER_WIDTH'(CORDIC_STEPS))
        else $error("rotation step count out of range");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !stat.out_busy) |=> state_reg == ST_IDLE)
        else $error("result hand-off did not return to idle");

    a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> !stat.out_busy)
        else $error("result loaded over an untaken result");

endmodule

### src/sso_dpath.sv
// Datapath for the odometry core: deltas, distance, rotation unit, shared
// multiplier, dividers and output register. Depends on sso_pkg.
`timescale 1ns / 1ps

module sso_dpath import sso_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [IN_WIDTH-1:0]    in_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_WIDTH-1:0]   out_data,
    output logic [USER_WIDTH-1:0]  out_user,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [MPC_WIDTH-1:0]   cfg_data
);

    localparam int DM_WIDTH  = 48;
    localparam int SUM_WIDTH = COUNT_WIDTH + 2;

    logic [MPC_WIDTH-1:0]      mpc_reg;
    logic [LIMIT_WIDTH-1:0]    limit_reg;
    logic [COUNT_WIDTH-1:0]    last_cnt_reg [4];
    logic [ANGLE_WIDTH-1:0]    last_yaw_reg;
    logic [POSITION_WIDTH-1:0] pos_x_reg, pos_y_reg;
    logic [ANGLE_WIDTH-1:0]    heading_reg;
    logic                      out_valid_reg;

    logic [COUNT_WIDTH-1:0]         delta_reg [4];
    logic [ANGLE_WIDTH-1:0]         dyaw_reg;
    logic [TIME_WIDTH-1:0]          t_reg;
    logic                           glitch_reg;
    logic signed [COUNT_WIDTH:0]    left_reg, right_reg;
    logic signed [SUM_WIDTH-1:0]    sum_reg;
    logic [SUM_WIDTH-1:0]           msum_reg;
    logic                           dist_neg_reg;
    logic signed [ANGLE_WIDTH-1:0]  dth_reg;
    logic [63:0]                    mul_reg, p0_reg;
    logic [DM_WIDTH-1:0]            dm_reg;
    logic [1:0]                     q_reg;
    logic signed [CORDIC_WIDTH-1:0] cx_reg, cy_reg, cz_reg;
    logic [31:0]                    cmag_reg, smag_reg;
    logic                           cneg_reg, sneg_reg;
    logic [POSITION_WIDTH-1:0]      mx_reg, my_reg;
    logic [63:0]                    numl_reg;
    logic [35:0]                    numa_reg;
    logic                           bigl_reg, biga_reg;
    logic [TIME_WIDTH-1:0]          reml_reg, rema_reg;
    logic [31:0]                    quol_reg, quoa_reg;
    logic [OUT_WIDTH-1:0]           out_data_reg;
    logic [USER_WIDTH-1:0]          out_user_reg;

    logic [COUNT_WIDTH-1:0]         cnt_in [4];
    logic [ANGLE_WIDTH-1:0]         yaw_in;
    logic [TIME_WIDTH-1:0]          t_in;
    logic [31:0]                    mul_a, mul_b;
    logic [3:0]                     over;
    logic signed [SUM_WIDTH-1:0]    sum_c;
    logic signed [ANGLE_WIDTH-1:0]  dth_c;
    logic [63:0]                    comb_q18, comb_q30, comb_n;
    logic [ANGLE_WIDTH-1:0]         hq_c;
    logic [1:0]                     q_c;
    logic signed [ANGLE_WIDTH-1:0]  r_c;
    logic signed [CORDIC_WIDTH-1:0] xs_c, ys_c, at_c, c_c, s_c;
    logic [ANGLE_WIDTH-1:0]         dth_mag;
    logic [TIME_WIDTH:0]            reml2, rema2;
    logic                           gel, gea;
    logic [VEL_WIDTH-1:0]           lin_c, ang_c;

    function automatic logic [VEL_WIDTH-1:0] vel(input logic big, input logic neg,
                                                  input logic [31:0] quo);
        logic [VEL_WIDTH-1:0] v;
        if (big)
            v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (neg)
            v = (quo > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo);
        else
            v = quo[31] ? 32'h7FFF_FFFF : quo;
        return v;
    endfunction

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cnt_in[k] = in_data[k*COUNT_WIDTH +: COUNT_WIDTH];
        end
    end
    assign yaw_in = in_data[4*COUNT_WIDTH +: ANGLE_WIDTH];
    assign t_in   = in_data[4*COUNT_WIDTH + ANGLE_WIDTH +: TIME_WIDTH];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            over[k] = (delta_reg[k][COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - delta_reg[k])
                                                   : delta_reg[k]) > {1'b0, limit_reg};
        end
    end

    assign sum_c = SUM_WIDTH'(left_reg) + SUM_WIDTH'(right_reg);
    assign dth_c = (left_reg != '0 || right_reg != '0) ? dyaw_reg : '0;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MD_LO: begin mul_a = msum_reg[31:0];                 mul_b = mpc_reg;  end
            OP_MD_HI: begin mul_a = {30'b0, msum_reg[33:32]};       mul_b = mpc_reg;  end
            OP_XLO:   begin mul_a = dm_reg[31:0];                   mul_b = cmag_reg; end
            OP_XHI:   begin mul_a = {16'b0, dm_reg[47:32]};         mul_b = cmag_reg; end
            OP_YLO:   begin mul_a = dm_reg[31:0];                   mul_b = smag_reg; end
            OP_YHI:   begin mul_a = {16'b0, dm_reg[47:32]};         mul_b = smag_reg; end
            OP_NLO:   begin mul_a = dm_reg[31:0];                   mul_b = US_PER_S; end
            OP_NHI:   begin mul_a = {16'b0, dm_reg[47:32]};         mul_b = US_PER_S; end
            default:  begin mul_a = '0;                             mul_b = '0;       end
        endcase
    end

    assign comb_q18 = (mul_reg << 14) + (p0_reg >> 18);
    assign comb_q30 = (mul_reg << 2) + (p0_reg >> 30);
    assign comb_n   = (mul_reg << 32) + p0_reg;

    assign hq_c = heading_reg + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
    assign q_c  = hq_c[ANGLE_WIDTH-1 -: 2];
    assign r_c  = heading_reg - {q_c, {(ANGLE_WIDTH-2){1'b0}}};

    assign xs_c = cx_reg >>> cmd.iter;
    assign ys_c = cy_reg >>> cmd.iter;
    assign at_c = atan_step(cmd.iter);

    always_comb
    begin
        case (q_reg)
            2'd0:    begin c_c = cx_reg;  s_c = cy_reg;  end
            2'd1:    begin c_c = -cy_reg; s_c = cx_reg;  end
            2'd2:    begin c_c = -cx_reg; s_c = -cy_reg; end
            default: begin c_c = cy_reg;  s_c = -cx_reg; end
        endcase
    end

    assign dth_mag = dth_reg[ANGLE_WIDTH-1] ? (ANGLE_WIDTH'(0) - dth_reg) : dth_reg;

    assign reml2 = {reml_reg, quol_reg[31]};
    assign rema2 = {rema_reg, quoa_reg[31]};
    assign gel   = reml2 >= {1'b0, t_reg};
    assign gea   = rema2 >= {1'b0, t_reg};

    assign lin_c = (t_reg == '0) ? '0 : vel(bigl_reg, dist_neg_reg, quol_reg);
    assign ang_c = (t_reg == '0) ? '0 : vel(biga_reg, dth_reg[ANGLE_WIDTH-1], quoa_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpc_reg       <= MPC_RESET;
            limit_reg     <= LIMIT_RESET;
            for (int k = 0; k < 4; k++)
            begin
                last_cnt_reg[k] <= '0;
            end
            last_yaw_reg  <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MPC:   mpc_reg   <= cfg_data;
                    REG_LIMIT: limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                    default:   mpc_reg   <= mpc_reg;
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    last_cnt_reg[k] <= cnt_in[k];
                end
                last_yaw_reg <= yaw_in;
            end
            if (cmd.op == OP_SUM)
                heading_reg <= heading_reg + dth_c;
            if (cmd.op == OP_YHI)
                pos_x_reg <= (dist_neg_reg ^ cneg_reg) ? pos_x_reg - mx_reg : pos_x_reg + mx_reg;
            if (cmd.op == OP_NLO)
                pos_y_reg <= (dist_neg_reg ^ sneg_reg) ? pos_y_reg - my_reg : pos_y_reg + my_reg;
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    delta_reg[k] <= cnt_in[k] - last_cnt_reg[k];
                end
                dyaw_reg <= yaw_in - last_yaw_reg;
                t_reg    <= t_in;
            end
            OP_GLITCH: glitch_reg <= |over;
            OP_SUMS:
            begin
                if (glitch_reg)
                begin
                    left_reg  <= '0;
                    right_reg <= '0;
                end
                else
                begin
                    left_reg  <= (COUNT_WIDTH+1)'($signed(delta_reg[0]))
                               + (COUNT_WIDTH+1)'($signed(delta_reg[2]));
                    right_reg <= (COUNT_WIDTH+1)'($signed(delta_reg[1]))
                               + (COUNT_WIDTH+1)'($signed(delta_reg[3]));
                end
            end
            OP_SUM:
            begin
                sum_reg <= sum_c;
                dth_reg <= dth_c;
            end
            OP_MAG:
            begin
                msum_reg     <= sum_reg[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum_reg) : sum_reg;
                dist_neg_reg <= sum_reg[SUM_WIDTH-1];
            end
            OP_MD_HI: p0_reg <= mul_reg;
            OP_DIST:  dm_reg <= comb_q18[DM_WIDTH-1:0];
            OP_CINIT:
            begin
                q_reg  <= q_c;
                cx_reg <= CORDIC_GAIN;
                cy_reg <= '0;
                cz_reg <= CORDIC_WIDTH'(r_c) <<< (32 - ANGLE_WIDTH);
            end
            OP_CSTEP:
            begin
                if (!cz_reg[CORDIC_WIDTH-1])
                begin
                    cx_reg <= cx_reg - ys_c;
                    cy_reg <= cy_reg + xs_c;
                    cz_reg <= cz_reg - at_c;
                end
                else
                begin
                    cx_reg <= cx_reg + ys_c;
                    cy_reg <= cy_reg - xs_c;
                    cz_reg <= cz_reg + at_c;
                end
            end
            OP_CROT:
            begin
                cneg_reg <= c_c[CORDIC_WIDTH-1];
                sneg_reg <= s_c[CORDIC_WIDTH-1];
                cmag_reg <= c_c[CORDIC_WIDTH-1] ? 32'(-c_c) : c_c[31:0];
                smag_reg <= s_c[CORDIC_WIDTH-1] ? 32'(-s_c) : s_c[31:0];
            end
            OP_XHI:  p0_reg <= mul_reg;
            OP_YLO:  mx_reg <= comb_q30[POSITION_WIDTH-1:0];
            OP_YHI:  p0_reg <= mul_reg;
            OP_POSY: my_reg <= comb_q30[POSITION_WIDTH-1:0];
            OP_NHI:  p0_reg <= mul_reg;
            OP_DINIT:
            begin
                numl_reg <= comb_n;
                numa_reg <= 36'(dth_mag) * 36'(US_PER_S);
            end
            OP_DPRE:
            begin
                bigl_reg <= (dm_reg[DM_WIDTH-1:43] != '0) || (numl_reg[63:32] >= 32'(t_reg));
                biga_reg <= 24'(numa_reg[35:32]) >= t_reg;
                reml_reg <= numl_reg[32 +: TIME_WIDTH];
                quol_reg <= numl_reg[31:0];
                rema_reg <= 24'(numa_reg[35:32]);
                quoa_reg <= numa_reg[31:0];
            end
            OP_DSTEP:
            begin
                reml_reg <= gel ? TIME_WIDTH'(reml2 - {1'b0, t_reg}) : reml2[TIME_WIDTH-1:0];
                rema_reg <= gea ? TIME_WIDTH'(rema2 - {1'b0, t_reg}) : rema2[TIME_WIDTH-1:0];
                quol_reg <= {quol_reg[30:0], gel};
                quoa_reg <= {quoa_reg[30:0], gea};
            end
            OP_OUT:
            begin
                out_data_reg <= {ang_c, lin_c, heading_reg, pos_y_reg, pos_x_reg};
                out_user_reg <= {(t_reg == '0), glitch_reg};
            end
            default: p0_reg <= p0_reg;
        endcase
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_user      = out_user_reg;

endmodule

### src/skid_steer_odometry_core.sv
// Skid-steer odometry core top level: sequencer plus datapath.
// Processing time is set by the 30-step rotation loop and the 32-step
// shift-subtract dividers that run one step per cycle; a new transaction is
// accepted only once the previous result is in the output register.
// Reset: rst_n clears stored counts, yaw, position and heading to zero and
// loads default register values; no clearing pass is needed.
`timescale 1ns / 1ps

module skid_steer_odometry_core import sso_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // front_left_count, front_right_count, back_left_count, back_right_count,
    // yaw, elapsed_us
    input  logic [IN_WIDTH-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // x_position, y_position, heading, linear_velocity, angular_velocity
    output logic [OUT_WIDTH-1:0]  m_axis_tdata,
    // glitch, zero_time
    output logic [USER_WIDTH-1:0] m_axis_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [MPC_WIDTH-1:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    sso_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sso_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
